// ===== rtl/rmcpe_pkg.sv =====
// Shared types and constants for the RMC sentence position extractor.
package rmcpe_pkg;

    // The port field is one bit wide, so at most two ports hold state.
    localparam int NUM_SLOTS = 2;

    localparam int HDR_LEN = 5;
    localparam int LAT_LEN = 9;
    localparam int LON_LEN = 10;
    localparam int RUN_LEN = LAT_LEN + LON_LEN;

    localparam logic [8:0] COUNT_CAP = 9'd511;

    // Buffer positions that are captured.
    localparam logic [8:0] POS_HDR_FIRST = 9'd1;
    localparam logic [8:0] POS_HDR_LAST  = 9'd5;
    localparam logic [8:0] POS_STATUS    = 9'd18;
    localparam logic [8:0] POS_LAT_FIRST = 9'd20;
    localparam logic [8:0] POS_LAT_LAST  = 9'd28;
    localparam logic [8:0] POS_HEMI      = 9'd30;
    localparam logic [8:0] POS_LON_FIRST = 9'd32;
    localparam logic [8:0] POS_LON_LAST  = 9'd41;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_N      = 8'h4E;

    localparam logic [1:0] KIND_LAT = 2'd0;
    localparam logic [1:0] KIND_LON = 2'd1;
    localparam logic [1:0] KIND_OVF = 2'd2;

    localparam logic [4:0] ITEM_LAST = 5'(RUN_LEN - 1);

    typedef struct packed {
        logic       port;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic       port_out;
        logic [1:0] kind;
        logic [3:0] char_index;
        logic [7:0] char_value;
        logic       last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EMIT,
        ST_OVF
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       byte_en;
        logic       go_idle;
        logic       load_item;
        logic       load_ovf;
        logic [4:0] item_idx;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic lf_end;
        logic is_void;
        logic is_north;
        logic overflow;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/rmcpe_dp.sv =====
// Datapath: per-port sentence state, field captures and the result register.
module rmcpe_dp #(
    parameter int NUM_PORTS = 2,
    parameter int MAX_LEN   = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rmcpe_pkg::in_item_t  s_item,
    input  rmcpe_pkg::ctl_cmd_t  cmd,
    output rmcpe_pkg::dp_status_t status,
    input  logic                 m_ready,
    output logic                 m_valid,
    output rmcpe_pkg::out_item_t m_item
);
    import rmcpe_pkg::*;

    localparam logic [8:0] MAX_LEN_C = 9'(MAX_LEN);

    logic       receiving_reg [NUM_SLOTS];
    logic [8:0] count_reg     [NUM_SLOTS];
    logic [7:0] header_reg    [NUM_SLOTS][HDR_LEN];
    logic [7:0] status_reg    [NUM_SLOTS];
    logic [7:0] hemi_reg      [NUM_SLOTS];
    logic [7:0] lat_reg       [NUM_SLOTS][LAT_LEN];
    logic [7:0] lon_reg       [NUM_SLOTS][LON_LEN];

    logic       pend_port_reg;
    logic       m_valid_reg, m_valid_next;
    out_item_t  m_item_reg, m_item_next;

    logic       port_ok;
    logic       is_dollar;
    logic       byte_live;
    logic       cap_en;
    logic [8:0] pos;
    logic [8:0] hdr_off, lat_off, lon_off;
    logic       hit_hdr, hit_status, hit_lat, hit_hemi, hit_lon;
    logic       is_rmc;
    logic [4:0] lon_idx;
    logic [7:0] item_char;

    assign port_ok   = (int'(s_item.port) < NUM_PORTS);
    assign is_dollar = (s_item.rx_byte == CH_DOLLAR);
    // A non-'$' byte on a receiving port belongs to the current sentence.
    assign byte_live = cmd.byte_en && port_ok && !is_dollar && receiving_reg[s_item.port];

    assign pos     = count_reg[s_item.port];
    assign cap_en  = byte_live && (pos < COUNT_CAP);
    assign hdr_off = pos - POS_HDR_FIRST;
    assign lat_off = pos - POS_LAT_FIRST;
    assign lon_off = pos - POS_LON_FIRST;

    always_comb begin
        hit_hdr    = (pos >= POS_HDR_FIRST) && (pos <= POS_HDR_LAST);
        hit_status = (pos == POS_STATUS);
        hit_lat    = (pos >= POS_LAT_FIRST) && (pos <= POS_LAT_LAST);
        hit_hemi   = (pos == POS_HEMI);
        hit_lon    = (pos >= POS_LON_FIRST) && (pos <= POS_LON_LAST);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < NUM_SLOTS; p++) begin
                receiving_reg[p] <= 1'b0;
                count_reg[p]     <= '0;
                status_reg[p]    <= '0;
                hemi_reg[p]      <= '0;
                for (int i = 0; i < HDR_LEN; i++) header_reg[p][i] <= '0;
                for (int i = 0; i < LAT_LEN; i++) lat_reg[p][i] <= '0;
                for (int i = 0; i < LON_LEN; i++) lon_reg[p][i] <= '0;
            end
            pend_port_reg <= 1'b0;
        end else begin
            if (cmd.byte_en && port_ok && is_dollar) begin
                receiving_reg[s_item.port] <= 1'b1;
                count_reg[s_item.port]     <= 9'd1;
            end
            if (cap_en) begin
                count_reg[s_item.port] <= pos + 9'd1;
                if (hit_hdr) header_reg[s_item.port][hdr_off[2:0]] <= s_item.rx_byte;
                if (hit_status) status_reg[s_item.port] <= s_item.rx_byte;
                if (hit_lat) lat_reg[s_item.port][lat_off[3:0]] <= s_item.rx_byte;
                if (hit_hemi) hemi_reg[s_item.port] <= s_item.rx_byte;
                if (hit_lon) lon_reg[s_item.port][lon_off[3:0]] <= s_item.rx_byte;
            end
            if (cmd.byte_en) begin
                pend_port_reg <= s_item.port;
            end
            if (cmd.go_idle) begin
                receiving_reg[pend_port_reg] <= 1'b0;
                count_reg[pend_port_reg]     <= '0;
            end
        end
    end

    assign is_rmc = (header_reg[pend_port_reg][0] == CH_G) &&
                    (header_reg[pend_port_reg][1] == CH_P) &&
                    (header_reg[pend_port_reg][2] == CH_R) &&
                    (header_reg[pend_port_reg][3] == CH_M) &&
                    (header_reg[pend_port_reg][4] == CH_C);

    always_comb begin
        status.lf_end   = byte_live && (s_item.rx_byte == CH_LF);
        status.is_void  = is_rmc && (status_reg[pend_port_reg] == CH_V);
        status.is_north = is_rmc && (status_reg[pend_port_reg] == CH_A) &&
                          (hemi_reg[pend_port_reg] == CH_N);
        status.overflow = (count_reg[pend_port_reg] > MAX_LEN_C);
        status.out_free = !m_valid_reg || m_ready;
    end

    assign lon_idx = cmd.item_idx - 5'(LAT_LEN);

    always_comb begin
        if (cmd.item_idx < 5'(LAT_LEN)) begin
            item_char = lat_reg[pend_port_reg][cmd.item_idx[3:0]];
        end else begin
            item_char = lon_reg[pend_port_reg][lon_idx[3:0]];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        if (cmd.load_item) begin
            m_valid_next        = 1'b1;
            m_item_next.port_out = pend_port_reg;
            if (cmd.item_idx < 5'(LAT_LEN)) begin
                m_item_next.kind       = KIND_LAT;
                m_item_next.char_index = cmd.item_idx[3:0];
            end else begin
                m_item_next.kind       = KIND_LON;
                m_item_next.char_index = lon_idx[3:0];
            end
            m_item_next.char_value = item_char;
            m_item_next.last       = (cmd.item_idx == ITEM_LAST);
        end else if (cmd.load_ovf) begin
            m_valid_next           = 1'b1;
            m_item_next.port_out   = pend_port_reg;
            m_item_next.kind       = KIND_OVF;
            m_item_next.char_index = '0;
            m_item_next.char_value = '0;
            m_item_next.last       = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// ===== rtl/rmcpe_ctrl.sv =====
// Controller: sequences byte intake, the end-of-sentence check and the result run.
module rmcpe_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rmcpe_pkg::dp_status_t status,
    output rmcpe_pkg::ctl_cmd_t   cmd
);
    import rmcpe_pkg::*;

    state_t     state_reg, state_next;
    logic [4:0] idx_reg, idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && status.lf_end) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                idx_next = '0;
                if (status.is_north) begin
                    state_next = ST_EMIT;
                end else if (status.is_void) begin
                    state_next = ST_IDLE;
                end else if (status.overflow) begin
                    state_next = ST_OVF;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    idx_next = idx_reg + 5'd1;
                    if (idx_reg == ITEM_LAST) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OVF: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd.byte_en   = 1'b0;
        cmd.go_idle   = 1'b0;
        cmd.load_item = 1'b0;
        cmd.load_ovf  = 1'b0;
        cmd.item_idx  = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.byte_en = s_valid;
            end
            ST_CHECK: begin
                // A sentence that starts a run, is void or overflowed leaves the port
                // idle; the run that follows reads captures only.
                cmd.go_idle = status.is_north || status.is_void || status.overflow;
            end
            ST_EMIT: begin
                cmd.load_item = status.out_free;
            end
            ST_OVF: begin
                cmd.load_ovf = status.out_free;
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/nmea_rmc_position_extractor_unit.sv =====
// Top level of the RMC sentence position extractor.
//
// Input channel (s_valid/s_ready/s_item): one received byte per request,
// tagged with the serial port it came in on. Each port keeps its own
// sentence state; bytes for ports at or above NUM_PORTS are dropped.
// Result channel (m_valid/m_ready/m_item): a valid position sentence from
// the northern hemisphere gives a run of nine latitude and ten longitude
// characters, the last flagged; an overlong sentence that gives no run and
// is not void gives one overflow item.
// Ordinary bytes are taken one per cycle while the controller is idle; a
// line feed on a receiving port brings the end-of-sentence check, during
// which no byte is taken. A run is loaded item by item from the emit state
// after the check; the input stays blocked until its last item is loaded.
// The single output register holds a finished result while new bytes are
// taken; while the receiver stalls, a run simply pauses.
// Reset (aresetn low, synchronous) returns every port to idle, clears all
// captured characters and empties the output register.
module nmea_rmc_position_extractor_unit #(
    parameter int NUM_PORTS = 2,
    parameter int MAX_LEN   = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rmcpe_pkg::in_item_t  s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rmcpe_pkg::out_item_t m_item
);
    import rmcpe_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t status;

    rmcpe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rmcpe_dp #(
        .NUM_PORTS (NUM_PORTS),
        .MAX_LEN   (MAX_LEN)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .status  (status),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_item  (m_item)
    );

endmodule
